FILE: design/afd_pkg.sv
// Shared types, constants and register indexes for the audio frame deframer.
// Used by every module of the block; depends on nothing else.
package afd_pkg;

    localparam int COUNT_WIDTH = 20;
    localparam int HDR_BYTES = 1 + 1 + 4 + 8 + 8 + 4;
    localparam int CODEC_POS = 0;
    localparam int CHAN_POS = 1;
    localparam int RATE_END = 6;
    localparam int SEQ_END = 14;
    localparam int TS_END = 22;
    localparam int ALIGN_CH_LIMIT = 8;
    localparam int PHASE_WIDTH = 4;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int MAX_PAYLOAD_WIDTH = 19;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PCM_CODEC = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OPUS_CODEC = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_PAYLOAD = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_RATE = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_RATE = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_CHANNELS = 3'd5;

    // Frame status codes, listed by priority.
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_TRUNCATED = 3'd1;
    localparam logic [2:0] ST_CODEC = 3'd2;
    localparam logic [2:0] ST_LENGTH = 3'd3;
    localparam logic [2:0] ST_CHANNELS = 3'd4;
    localparam logic [2:0] ST_RATE = 3'd5;
    localparam logic [2:0] ST_TIMESTAMP = 3'd6;
    localparam logic [2:0] ST_UNALIGNED = 3'd7;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_done;
        logic [2:0]  status;
        logic        codec_is_opus;
        logic [7:0]  channel_count;
        logic [31:0] rate_hz;
        logic [63:0] sequence_number;
        logic [63:0] stamp_ms;
        logic [31:0] payload_length;
    } out_item_t;

    typedef struct packed {
        logic [7:0]                   pcm_codec_code;
        logic [7:0]                   opus_codec_code;
        logic [MAX_PAYLOAD_WIDTH-1:0] max_payload_bytes;
        logic [31:0]                  min_rate_hz;
        logic [31:0]                  max_rate_hz;
        logic [3:0]                   max_channel_count;
    } cfg_t;

    // Per-frame state: byte counter, captured header fields and PCM phase.
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] byte_count;
        logic [7:0]             codec_byte;
        logic [7:0]             channels;
        logic [31:0]            rate;
        logic [63:0]            seq_num;
        logic [63:0]            timestamp;
        logic [31:0]            length;
        logic [PHASE_WIDTH-1:0] align_phase;
    } frame_t;

endpackage

FILE: design/afd_frame_state.sv
// Frame state of the audio frame deframer: byte counter, header capture and
// PCM alignment phase. Depends on afd_pkg.
module afd_frame_state
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [7:0]        in_byte,
    input  logic              end_of_frame,
    output afd_pkg::frame_t   frame_cur,
    output afd_pkg::frame_t   frame_upd
);

    afd_pkg::frame_t frame_reg;
    logic [afd_pkg::PHASE_WIDTH:0] phase_inc;
    logic [afd_pkg::PHASE_WIDTH:0] phase_limit;

    assign frame_cur = frame_reg;

    // State after taking in this byte, before the end-of-frame clear.
    always_comb
    begin
        frame_upd = frame_reg;
        phase_inc = {1'b0, frame_reg.align_phase} + 1'b1;
        phase_limit = {frame_reg.channels[afd_pkg::PHASE_WIDTH-1:0], 1'b0};
        if (frame_reg.byte_count == afd_pkg::COUNT_WIDTH'(afd_pkg::CODEC_POS))
        begin
            frame_upd.codec_byte = in_byte;
        end
        else if (frame_reg.byte_count == afd_pkg::COUNT_WIDTH'(afd_pkg::CHAN_POS))
        begin
            frame_upd.channels = in_byte;
        end
        else if (frame_reg.byte_count < afd_pkg::COUNT_WIDTH'(afd_pkg::RATE_END))
        begin
            frame_upd.rate = {frame_reg.rate[23:0], in_byte};
        end
        else if (frame_reg.byte_count < afd_pkg::COUNT_WIDTH'(afd_pkg::SEQ_END))
        begin
            frame_upd.seq_num = {frame_reg.seq_num[55:0], in_byte};
        end
        else if (frame_reg.byte_count < afd_pkg::COUNT_WIDTH'(afd_pkg::TS_END))
        begin
            frame_upd.timestamp = {frame_reg.timestamp[55:0], in_byte};
        end
        else if (frame_reg.byte_count < afd_pkg::COUNT_WIDTH'(afd_pkg::HDR_BYTES))
        begin
            frame_upd.length = {frame_reg.length[23:0], in_byte};
        end
        else if (frame_reg.channels != 8'd0 &&
                 frame_reg.channels <= 8'(afd_pkg::ALIGN_CH_LIMIT))
        begin
            // Phase runs modulo twice the channel count.
            frame_upd.align_phase = (phase_inc >= phase_limit) ? '0
                                  : phase_inc[afd_pkg::PHASE_WIDTH-1:0];
        end
        else
        begin
            frame_upd.align_phase = '0;
        end

        if (frame_reg.byte_count != afd_pkg::COUNT_MAX)
        begin
            frame_upd.byte_count = frame_reg.byte_count + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
        end
        else if (advance)
        begin
            frame_reg <= end_of_frame ? '0 : frame_upd;
        end
    end

endmodule

FILE: design/afd_status.sv
// Prioritized end-of-frame status check and codec decode.
// Depends on afd_pkg.
module afd_status
(
    input  afd_pkg::frame_t frame,
    input  afd_pkg::cfg_t   cfg,
    output logic [2:0]      status,
    output logic            codec_is_opus
);

    logic        is_pcm;
    logic        is_opus;
    logic [3:0]  ch_max;
    logic [32:0] expected_count;
    logic        bad_length;

    always_comb
    begin
        is_pcm = frame.codec_byte == cfg.pcm_codec_code;
        is_opus = !is_pcm && frame.codec_byte == cfg.opus_codec_code;
        ch_max = (cfg.max_channel_count < 4'(afd_pkg::ALIGN_CH_LIMIT))
               ? cfg.max_channel_count : 4'(afd_pkg::ALIGN_CH_LIMIT);
        expected_count = {1'b0, frame.length} + 33'(afd_pkg::HDR_BYTES);
        bad_length = frame.byte_count == afd_pkg::COUNT_MAX
                  || frame.length == 32'd0
                  || frame.length > 32'(cfg.max_payload_bytes)
                  || 33'(frame.byte_count) != expected_count;

        if (frame.byte_count < afd_pkg::COUNT_WIDTH'(afd_pkg::HDR_BYTES))
        begin
            status = afd_pkg::ST_TRUNCATED;
        end
        else if (!is_pcm && !is_opus)
        begin
            status = afd_pkg::ST_CODEC;
        end
        else if (bad_length)
        begin
            status = afd_pkg::ST_LENGTH;
        end
        else if (frame.channels == 8'd0 || frame.channels > 8'(ch_max))
        begin
            status = afd_pkg::ST_CHANNELS;
        end
        else if (frame.rate < cfg.min_rate_hz || frame.rate > cfg.max_rate_hz)
        begin
            status = afd_pkg::ST_RATE;
        end
        else if (frame.timestamp == 64'd0)
        begin
            status = afd_pkg::ST_TIMESTAMP;
        end
        else if (is_pcm && frame.align_phase != '0)
        begin
            status = afd_pkg::ST_UNALIGNED;
        end
        else
        begin
            status = afd_pkg::ST_OK;
        end
        codec_is_opus = is_opus;
    end

endmodule

FILE: design/audio_frame_deframer.sv
// Audio frame deframer top level: input register, frame state, status check,
// result register and configuration registers. Depends on afd_pkg,
// afd_frame_state and afd_status.
// Path: an accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle while the consumer does not stall the result register.
// Reset: rst_n clears frame state and valid flags, and restores config defaults.
module audio_frame_deframer
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    item_valid,
    output logic                                    item_stall,
    input  afd_pkg::in_item_t                       item,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output afd_pkg::out_item_t                      result,
    input  logic                                    cfg_write,
    input  logic [afd_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [afd_pkg::CFG_DATA_WIDTH-1:0]      cfg_data
);

    // Input register. It holds one byte; the item stalls only while that byte
    // cannot move into the result register.
    logic               item_valid_reg;
    afd_pkg::in_item_t  item_reg;

    // Result register, freed when the consumer takes the transfer.
    logic               result_valid_reg;
    afd_pkg::out_item_t result_reg;
    afd_pkg::out_item_t result_next;

    afd_pkg::cfg_t      cfg_reg;
    afd_pkg::frame_t    frame_cur;
    afd_pkg::frame_t    frame_upd;
    logic [2:0]         check_status;
    logic               check_opus;
    logic               advance;
    logic               item_take;

    // The held byte moves on when the result register is empty or draining.
    assign advance = item_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = item_valid_reg && !advance;
    assign item_take = item_valid && !item_stall;

    assign result_valid = result_valid_reg;
    assign result = result_reg;

    afd_frame_state u_frame_state
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .in_byte      (item_reg.in_byte),
        .end_of_frame (item_reg.end_of_frame),
        .frame_cur    (frame_cur),
        .frame_upd    (frame_upd)
    );

    afd_status u_status
    (
        .frame         (frame_upd),
        .cfg           (cfg_reg),
        .status        (check_status),
        .codec_is_opus (check_opus)
    );

    // Result fields. The header fields show the capture after this byte, and
    // a byte is payload when it arrived past the header.
    always_comb
    begin
        result_next.payload_valid = frame_cur.byte_count
                                  >= afd_pkg::COUNT_WIDTH'(afd_pkg::HDR_BYTES);
        result_next.payload_byte = result_next.payload_valid ? item_reg.in_byte : 8'd0;
        result_next.frame_done = item_reg.end_of_frame;
        result_next.status = item_reg.end_of_frame ? check_status : afd_pkg::ST_OK;
        result_next.codec_is_opus = check_opus;
        result_next.channel_count = frame_upd.channels;
        result_next.rate_hz = frame_upd.rate;
        result_next.sequence_number = frame_upd.seq_num;
        result_next.stamp_ms = frame_upd.timestamp;
        result_next.payload_length = frame_upd.length;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // Configuration registers. Indexes past the last register are ignored, and
    // data bits above a register's width are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pcm_codec_code <= 8'd0;
            cfg_reg.opus_codec_code <= 8'd1;
            cfg_reg.max_payload_bytes <= afd_pkg::MAX_PAYLOAD_WIDTH'(256 * 1024);
            cfg_reg.min_rate_hz <= 32'd8000;
            cfg_reg.max_rate_hz <= 32'd192000;
            cfg_reg.max_channel_count <= 4'(afd_pkg::ALIGN_CH_LIMIT);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                afd_pkg::CFG_PCM_CODEC:    cfg_reg.pcm_codec_code <= cfg_data[7:0];
                afd_pkg::CFG_OPUS_CODEC:   cfg_reg.opus_codec_code <= cfg_data[7:0];
                afd_pkg::CFG_MAX_PAYLOAD:
                    cfg_reg.max_payload_bytes <= cfg_data[afd_pkg::MAX_PAYLOAD_WIDTH-1:0];
                afd_pkg::CFG_MIN_RATE:     cfg_reg.min_rate_hz <= cfg_data;
                afd_pkg::CFG_MAX_RATE:     cfg_reg.max_rate_hz <= cfg_data;
                afd_pkg::CFG_MAX_CHANNELS: cfg_reg.max_channel_count <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for audio_frame_deframer: builds frames from a directed table and
// from random generators, feeds them byte by byte and compares every result transfer with an
// in-bench model of the deframer. Depends on afd_pkg and the audio_frame_deframer design.
module tb;
    import afd_pkg::*;

    // About a thousand bytes are sent, so even at the slowest idling pace the limit leaves a
    // wide margin.
    localparam int unsigned CYCLE_LIMIT = 200_000;
    localparam int unsigned RANDOM_CHUNK = 50;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Register indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE_HI = 3'd7;

    // Traffic shapes: which side of the block idles more.
    typedef enum int {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_mode_t;

    // One frame as the stimulus sees it: header fields, the number of bytes actually sent
    // (which may cut the header short or disagree with the length field) and, for rows of
    // the directed table, an optional hand-typed final status.
    typedef struct packed {
        logic [7:0]  codec;
        logic [7:0]  chans;
        logic [31:0] rate;
        logic [63:0] seq;
        logic [63:0] ts;
        logic [31:0] len;
        logic [31:0] total;
        logic        typed;
        logic [2:0]  status;
    } frame_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       item_valid;
    logic                       item_stall;
    in_item_t                   item;
    logic                       result_valid;
    logic                       result_stall;
    out_item_t                  result;
    logic                       cfg_write;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    // Model of the block: its register file, its per-frame state and the results it
    // still owes, oldest first.
    cfg_t        model_cfg;
    frame_t      model_frame;
    out_item_t   pending_results[$];
    frame_row_t  directed_frames[$];

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned bytes_sent;
    int unsigned cycles;

    audio_frame_deframer u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Computes the result of one accepted byte and advances the frame state. Header bytes
    // shift into their capture registers, payload bytes step the PCM phase counter, and the
    // final byte of a frame picks the highest-priority error before the state is cleared.
    function automatic out_item_t deframe_predict(input in_item_t it);
        out_item_t              r;
        logic [COUNT_WIDTH-1:0] pos;
        logic [PHASE_WIDTH:0]   next_phase;
        logic [3:0]             ch_bound;
        logic                   is_pcm;
        logic                   is_opus;
        pos = model_frame.byte_count;
        r = '0;
        if (pos == CODEC_POS)
            model_frame.codec_byte = it.in_byte;
        else if (pos == CHAN_POS)
            model_frame.channels = it.in_byte;
        else if (pos < RATE_END)
            model_frame.rate = {model_frame.rate[23:0], it.in_byte};
        else if (pos < SEQ_END)
            model_frame.seq_num = {model_frame.seq_num[55:0], it.in_byte};
        else if (pos < TS_END)
            model_frame.timestamp = {model_frame.timestamp[55:0], it.in_byte};
        else if (pos < HDR_BYTES)
            model_frame.length = {model_frame.length[23:0], it.in_byte};
        else if (model_frame.channels >= 1 && model_frame.channels <= ALIGN_CH_LIMIT)
        begin
            // The phase wraps at twice the channel count, one PCM16 sample frame.
            next_phase = {1'b0, model_frame.align_phase} + 1'b1;
            if ({4'b0, next_phase} >= {model_frame.channels, 1'b0})
                model_frame.align_phase = '0;
            else
                model_frame.align_phase = next_phase[PHASE_WIDTH-1:0];
        end
        else
            model_frame.align_phase = '0;

        if (model_frame.byte_count != COUNT_MAX)
            model_frame.byte_count = model_frame.byte_count + 1'b1;

        // A codec byte that matches both codes counts as PCM16.
        is_pcm = model_frame.codec_byte == model_cfg.pcm_codec_code;
        is_opus = !is_pcm && model_frame.codec_byte == model_cfg.opus_codec_code;
        ch_bound = (model_cfg.max_channel_count < ALIGN_CH_LIMIT) ?
                   model_cfg.max_channel_count : 4'(ALIGN_CH_LIMIT);

        if (it.end_of_frame)
        begin
            if (model_frame.byte_count < HDR_BYTES)
                r.status = ST_TRUNCATED;
            else if (!is_pcm && !is_opus)
                r.status = ST_CODEC;
            else if (model_frame.byte_count == COUNT_MAX || model_frame.length == 0
                     || model_frame.length > model_cfg.max_payload_bytes
                     || 64'(model_frame.byte_count) != 64'(model_frame.length) + HDR_BYTES)
                r.status = ST_LENGTH;
            else if (model_frame.channels == 0 || model_frame.channels > ch_bound)
                r.status = ST_CHANNELS;
            else if (model_frame.rate < model_cfg.min_rate_hz
                     || model_frame.rate > model_cfg.max_rate_hz)
                r.status = ST_RATE;
            else if (model_frame.timestamp == 0)
                r.status = ST_TIMESTAMP;
            else if (is_pcm && model_frame.align_phase != 0)
                r.status = ST_UNALIGNED;
        end

        r.payload_valid = pos >= HDR_BYTES;
        r.payload_byte = r.payload_valid ? it.in_byte : 8'd0;
        r.frame_done = it.end_of_frame;
        r.codec_is_opus = is_opus;
        r.channel_count = model_frame.channels;
        r.rate_hz = model_frame.rate;
        r.sequence_number = model_frame.seq_num;
        r.stamp_ms = model_frame.timestamp;
        r.payload_length = model_frame.length;

        if (it.end_of_frame)
            model_frame = '0;
        return r;
    endfunction

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_RX_HEAVY:
            begin
                send_idle_pct = 19;
                recv_stall_pct = 60;
            end
            IDLE_TX_HEAVY:
            begin
                send_idle_pct = 60;
                recv_stall_pct = 19;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Offers one byte, holding it steady until the block takes it, then records what the
    // model says the matching result must be. Entered and left just after a falling edge.
    task automatic send_byte(input logic [7:0] value, input logic last, input logic typed,
                             input logic [2:0] typed_status);
        in_item_t  it;
        out_item_t want;
        it.in_byte = value;
        it.end_of_frame = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        want = deframe_predict(it);
        // Rows with a hand-typed status are held to that value instead of the model's.
        if (last && typed)
            want.status = typed_status;
        pending_results.insert(pending_results.size(), want);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Serializes a frame: the 26 header bytes big-endian, then random payload bytes, with
    // the end flag on whichever byte is last.
    task automatic send_frame(input frame_row_t f);
        logic [207:0] hdr;
        logic [7:0]   value;
        hdr = {f.codec, f.chans, f.rate, f.seq, f.ts, f.len};
        for (int unsigned i = 0; i < f.total; i++)
        begin
            if (i < HDR_BYTES)
                value = hdr[207 - 8 * i -: 8];
            else
                value = 8'($urandom);
            send_byte(value, i == f.total - 1, f.typed, f.status);
        end
    endtask

    // Stops offering bytes until every owed result has been taken.
    task automatic wait_for_results();
        item_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Drives one register write; the caller lowers the write enable after a batch.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        case (index)
            CFG_PCM_CODEC:    model_cfg.pcm_codec_code = data[7:0];
            CFG_OPUS_CODEC:   model_cfg.opus_codec_code = data[7:0];
            CFG_MAX_PAYLOAD:  model_cfg.max_payload_bytes = data[MAX_PAYLOAD_WIDTH-1:0];
            CFG_MIN_RATE:     model_cfg.min_rate_hz = data;
            CFG_MAX_RATE:     model_cfg.max_rate_hz = data;
            CFG_MAX_CHANNELS: model_cfg.max_channel_count = data[3:0];
            default:          ;
        endcase
        @(negedge clk);
    endtask

    // Rewrites every register once the block has gone quiet. The two spare indexes get
    // junk that must not land anywhere.
    task automatic load_config(input logic [31:0] pcm, input logic [31:0] opus,
                               input logic [31:0] max_pay, input logic [31:0] min_rate,
                               input logic [31:0] max_rate, input logic [31:0] max_ch);
        wait_for_results();
        write_reg(CFG_PCM_CODEC, pcm);
        write_reg(CFG_OPUS_CODEC, opus);
        write_reg(CFG_MAX_PAYLOAD, max_pay);
        write_reg(CFG_MIN_RATE, min_rate);
        write_reg(CFG_MAX_RATE, max_rate);
        write_reg(CFG_MAX_CHANNELS, max_ch);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic add_row(input logic [7:0] codec, input logic [7:0] chans,
                           input logic [31:0] rate, input logic [63:0] seq,
                           input logic [63:0] ts, input logic [31:0] len,
                           input int unsigned total, input logic typed,
                           input logic [2:0] status);
        directed_frames.insert(directed_frames.size(),
                               {codec, chans, rate, seq, ts, len, 32'(total), typed, status});
    endtask

    // Mostly well-formed frames that fit the current registers, so that most frames reach
    // the later checks; the rest break one field or the byte count, or are plain noise.
    function automatic frame_row_t random_frame();
        frame_row_t  f;
        int unsigned kind;
        int unsigned ch_lim;
        int unsigned len_cap;
        int unsigned len;
        f = '0;
        kind = $urandom_range(99);
        ch_lim = (model_cfg.max_channel_count < ALIGN_CH_LIMIT) ?
                 model_cfg.max_channel_count : ALIGN_CH_LIMIT;
        if (ch_lim == 0)
            ch_lim = 1;
        f.chans = 8'($urandom_range(ch_lim, 1));
        f.codec = $urandom_range(1) ? model_cfg.pcm_codec_code : model_cfg.opus_codec_code;
        if (model_cfg.min_rate_hz <= model_cfg.max_rate_hz)
        begin
            case ($urandom_range(3))
                0:       f.rate = model_cfg.min_rate_hz;
                1:       f.rate = model_cfg.max_rate_hz;
                default: f.rate = $urandom_range(model_cfg.max_rate_hz,
                                                 model_cfg.min_rate_hz);
            endcase
        end
        else
            f.rate = $urandom;
        f.seq = {$urandom, $urandom};
        f.ts = ($urandom_range(7) == 0) ? '1 : {$urandom, $urandom};
        if (f.ts == 0)
            f.ts = 64'd1;

        // PCM frames carry whole sample frames; short payloads keep the run quick.
        len_cap = (model_cfg.max_payload_bytes < 24) ? model_cfg.max_payload_bytes : 24;
        if (f.codec == model_cfg.pcm_codec_code)
            len = 2 * f.chans * $urandom_range(3, 1);
        else
            len = $urandom_range(len_cap, 1);
        if (len > len_cap)
            len = len_cap;
        f.len = len;
        f.total = HDR_BYTES + len;

        if (kind >= 70 && kind < 88)
        begin
            case ($urandom_range(6))
                0: f.codec = 8'($urandom);
                1: f.chans = 8'($urandom);
                2: f.rate = $urandom;
                3: f.ts = '0;
                4: f.len = $urandom_range(1) ? 32'($urandom_range(40)) : 32'($urandom);
                5: f.total = $urandom_range(1) ? f.total + $urandom_range(3, 1)
                                               : f.total - $urandom_range(3, 1);
                default: f.total = $urandom_range(HDR_BYTES - 1, 1);
            endcase
        end
        else if (kind >= 88)
        begin
            f.codec = 8'($urandom);
            f.chans = 8'($urandom);
            f.rate = $urandom;
            f.seq = {$urandom, $urandom};
            f.ts = {$urandom, $urandom};
            f.len = $urandom;
            f.total = $urandom_range(60, 1);
        end
        return f;
    endfunction

    task automatic run_random(input int unsigned budget);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            send_frame(random_frame());
            // Now and then the sender holds off until the block has fully drained.
            if ($urandom_range(11) == 0)
                wait_for_results();
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("Mismatch in %s on result %0d: expected %h, got %h",
                         name, results_seen, want, got);
        end
    endtask

    // The receiver stalls at random; the level is set at the falling edge so it is stable
    // when the block looks at it.
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < recv_stall_pct);

    // Every result transfer is matched against the oldest owed result, field by field.
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Result %0d arrived with nothing expected", results_seen);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("payload_valid", 64'(want.payload_valid),
                            64'(result.payload_valid));
                check_field("payload_byte", 64'(want.payload_byte), 64'(result.payload_byte));
                check_field("frame_done", 64'(want.frame_done), 64'(result.frame_done));
                check_field("status", 64'(want.status), 64'(result.status));
                check_field("codec_is_opus", 64'(want.codec_is_opus),
                            64'(result.codec_is_opus));
                check_field("channel_count", 64'(want.channel_count),
                            64'(result.channel_count));
                check_field("rate_hz", 64'(want.rate_hz), 64'(result.rate_hz));
                check_field("sequence_number", want.sequence_number, result.sequence_number);
                check_field("stamp_ms", want.stamp_ms, result.stamp_ms);
                check_field("payload_length", 64'(want.payload_length),
                            64'(result.payload_length));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        results_seen = 0;
        bytes_sent = 0;

        // Register values after reset, and an empty frame.
        model_cfg.pcm_codec_code = 8'd0;
        model_cfg.opus_codec_code = 8'd1;
        model_cfg.max_payload_bytes = 19'd262144;
        model_cfg.min_rate_hz = 32'd8000;
        model_cfg.max_rate_hz = 32'd192000;
        model_cfg.max_channel_count = 4'd8;
        model_frame = '0;

        // Directed frames under the reset registers. Final statuses typed in where they
        // are obvious; the last few rows rely on the model alone.
        //       codec  ch      rate           seq     ts       len         total typed
        add_row(8'hFF, 8'd0,   32'd0,         64'd0,  64'd0,   32'd0,      1,  1'b1,
                ST_TRUNCATED);
        add_row(8'h00, 8'd2,   32'd48000,     '1,     64'd1,   32'd4,      25, 1'b1,
                ST_TRUNCATED);
        add_row(8'h00, 8'd2,   32'd48000,     '1,     64'd1,   32'd4,      30, 1'b1, ST_OK);
        add_row(8'h01, 8'd1,   32'd8000,      64'd0,  '1,      32'd3,      29, 1'b1, ST_OK);
        add_row(8'hFF, 8'd2,   32'd48000,     64'd5,  64'd1,   32'd4,      30, 1'b1, ST_CODEC);
        // A bad codec outranks a zero length.
        add_row(8'hFF, 8'd2,   32'd48000,     64'd5,  64'd1,   32'd0,      26, 1'b1, ST_CODEC);
        add_row(8'h00, 8'd2,   32'd48000,     64'd6,  64'd1,   32'd0,      26, 1'b1, ST_LENGTH);
        add_row(8'h00, 8'd2,   32'd48000,     64'd7,  64'd1,   32'd4,      29, 1'b1, ST_LENGTH);
        add_row(8'h00, 8'd2,   32'd48000,     64'd8,  64'd1,   32'd262145, 30, 1'b1, ST_LENGTH);
        add_row(8'h00, 8'd0,   32'd48000,     64'd9,  64'd1,   32'd4,      30, 1'b1,
                ST_CHANNELS);
        add_row(8'h00, 8'd9,   32'd48000,     64'd9,  64'd1,   32'd4,      30, 1'b1,
                ST_CHANNELS);
        add_row(8'h00, 8'd255, 32'd48000,     64'd9,  64'd1,   32'd4,      30, 1'b1,
                ST_CHANNELS);
        add_row(8'h00, 8'd2,   32'd7999,      64'd10, 64'd1,   32'd4,      30, 1'b1, ST_RATE);
        add_row(8'h00, 8'd2,   32'd192001,    64'd10, 64'd1,   32'd4,      30, 1'b1, ST_RATE);
        add_row(8'h01, 8'd2,   32'hFFFF_FFFF, 64'd10, 64'd1,   32'd4,      30, 1'b1, ST_RATE);
        add_row(8'h00, 8'd2,   32'd48000,     64'd11, 64'd0,   32'd4,      30, 1'b1,
                ST_TIMESTAMP);
        add_row(8'h00, 8'd2,   32'd48000,     64'd12, 64'd1,   32'd3,      29, 1'b1,
                ST_UNALIGNED);
        add_row(8'h00, 8'd8,   32'd192000,    64'd13, 64'd1,   32'd16,     42, 1'b1, ST_OK);
        add_row(8'h00, 8'd3,   32'd44100,     64'd14, 64'd2,   32'd6,      32, 1'b0, ST_OK);
        add_row(8'h01, 8'd7,   32'd96000,     '1,     {1'b1, 63'd0}, 32'd5, 31, 1'b0, ST_OK);
        add_row(8'h02, 8'd4,   32'd22050,     64'd15, 64'd3,   32'd14,     40, 1'b0, ST_OK);

        // Reset is held low for a while, then released on a falling edge.
        set_idle(IDLE_RX_HEAVY);
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_frames[i])
            send_frame(directed_frames[i]);
        run_random(RANDOM_CHUNK);

        // Codes at the byte extremes with junk in the upper data bits, the smallest payload
        // limit, the widest rate window and a single channel.
        set_idle(IDLE_TX_HEAVY);
        load_config(32'hDEAD_BEFF, 32'h0000_0100, 32'hFFF8_0001, 32'd0, 32'hFFFF_FFFF,
                    32'hFFFF_FFF1);
        run_random(RANDOM_CHUNK);

        // Both codes equal, so every valid codec byte decodes as PCM16; a one-point rate
        // window.
        load_config(32'h5A, 32'h5A, 32'd300, 32'd44100, 32'd44100, 32'd4);
        run_random(RANDOM_CHUNK);

        // Minimum above maximum: every rate is out of bounds.
        set_idle(IDLE_NONE);
        load_config(32'd0, 32'd1, 32'd262144, 32'd96000, 32'd48000, 32'd8);
        run_random(RANDOM_CHUNK);

        load_config(32'd0, 32'd1, 32'd262144, 32'd8000, 32'd192000, 32'd8);
        run_random(RANDOM_CHUNK);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_results.size() != 0)
            mismatches++;

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: sim.f
design/afd_pkg.sv
design/afd_frame_state.sv
design/afd_status.sv
design/audio_frame_deframer.sv
tb/tb.sv
